// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the teletex identifier checker RTL.
// Concurrent assertions are compiled only for simulation; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define TIC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define TIC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define TIC_ASSERT(lbl, clk, rst_n, prop)
`define TIC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/tic_pkg.sv =====
// Package for the teletex terminal identifier checker: parse phases,
// character codes, key patterns and the printable-character test. No dependencies.
`timescale 1ns / 1ps

package tic_pkg;

    typedef enum logic [2:0] {
        PH_TERM = 3'd0,   // terminal identifier part (first element)
        PH_KEY  = 3'd1,   // collecting a key
        PH_VAL  = 3'd2,   // inside a key value
        PH_ESC1 = 3'd3,   // first escape digit expected
        PH_ESC2 = 3'd4    // second escape digit expected
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_TWO  = 2'd1,
        ESC_FIVE = 2'd2
    } esc_lead_t;

    localparam int unsigned KEY_BYTES   = 7;
    localparam int unsigned KEY_W       = 8 * KEY_BYTES;
    localparam logic [3:0]  KEY_CNT_MAX = 4'd8;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_UC_C   = 8'h43;
    localparam logic [7:0] CH_LC_C   = 8'h63;

    // Keys packed first octet highest, as the shift register holds them.
    localparam logic [KEY_W-1:0] KEY_MISC    = 56'h00_0000_6D69_7363;
    localparam logic [KEY_W-1:0] KEY_PAGE    = 56'h00_0000_7061_6765;
    localparam logic [KEY_W-1:0] KEY_GRAPHIC = 56'h67_7261_7068_6963;
    localparam logic [KEY_W-1:0] KEY_CONTROL = 56'h63_6F6E_7472_6F6C;
    localparam logic [KEY_W-1:0] KEY_PRIVATE = 56'h70_7269_7661_7465;

    // PrintableString character set.
    function automatic logic printable_octet(input logic [7:0] c);
        logic alnum;
        logic punct;
        alnum = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h30 && c <= 8'h39);
        punct = (c == 8'h27) || (c == 8'h28) || (c == 8'h29) || (c == 8'h2B) ||
                (c == 8'h2C) || (c == 8'h2D) || (c == 8'h2E) || (c == 8'h3D) ||
                (c == 8'h2F) || (c == 8'h3A) || (c == 8'h3F) || (c == 8'h20);
        return alnum || punct;
    endfunction

endpackage

// ===== hw/rtl/teletex_id_syntax_checker.sv =====
// Top level of the teletex terminal identifier syntax checker.
// Depends on tic_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Streams one octet of a value per beat and checks it against the teletex
// terminal identifier grammar: a printable first element, then '$'-separated
// elements of the form key ':' value with keys misc, page, graphic, control
// or private, where '\' in a value must start "\24" or "\5C"/"\5c". Each
// input beat lands in an input register; the parse state and the verdict are
// computed combinationally from it; the verdict is registered in the output
// register. It takes one beat per clock unless a verdict stalls. A beat with
// tlast set, or with tuser set (zero-length value, octet ignored), yields one
// output beat whose bit 0 is 1 for a valid value and 0 otherwise; every
// verdict returns the parser to its start state. The only stall comes from
// the output register: a verdict beat waits in the input register while an
// earlier verdict has not been taken, and no other beat ever waits there.
module teletex_id_syntax_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    input  logic       s_tuser,   // empty_value
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] value_ok, [7:1] zero
);
    import tic_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // Parse state.
    phase_t           phase_reg,    phase_next;
    logic [KEY_W-1:0] key_reg,      key_next;
    logic [3:0]       key_cnt_reg,  key_cnt_next;
    esc_lead_t        lead_reg,     lead_next;
    logic             err_reg,      err_next;
    logic             start_reg,    start_next;

    // Output register.
    logic out_valid_reg;
    logic out_ok_reg;
    logic ok_next;

    logic verdict;     // beat in the input register yields a result
    logic out_free;    // output register can take a result this cycle
    logic go;          // consume the beat in the input register
    logic in_take;
    logic key_ok;
    logic incomplete;

    assign verdict  = in_last_reg || in_empty_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign go       = in_valid_reg && (!verdict || out_free);
    assign s_tready = !in_valid_reg || go;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg};

    always_comb
    begin
        key_ok = 1'b0;
        if (key_cnt_reg == 4'd4)
        begin
            key_ok = (key_reg == KEY_MISC) || (key_reg == KEY_PAGE);
        end
        else if (key_cnt_reg == 4'd7)
        begin
            key_ok = (key_reg == KEY_GRAPHIC) || (key_reg == KEY_CONTROL) ||
                     (key_reg == KEY_PRIVATE);
        end
    end

    // Next parse state for the registered beat.
    always_comb
    begin
        phase_next   = phase_reg;
        key_next     = key_reg;
        key_cnt_next = key_cnt_reg;
        lead_next    = lead_reg;
        err_next     = err_reg;
        start_next   = start_reg;
        ok_next      = 1'b0;

        if (in_data_reg == CH_DOLLAR)
        begin
            // Element separator: reject leading, trailing, doubled or cut-off elements.
            if (start_reg || in_last_reg || phase_reg == PH_KEY ||
                phase_reg == PH_ESC1 || phase_reg == PH_ESC2)
            begin
                err_next = 1'b1;
            end
            phase_next   = PH_KEY;
            key_next     = '0;
            key_cnt_next = '0;
            lead_next    = ESC_NONE;
            start_next   = 1'b1;
        end
        else
        begin
            start_next = 1'b0;
            unique case (phase_reg)
                PH_TERM:
                begin
                    if (!printable_octet(in_data_reg))
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    if (in_data_reg == CH_COLON)
                    begin
                        if (!key_ok)
                        begin
                            err_next = 1'b1;
                        end
                        phase_next = PH_VAL;
                    end
                    else
                    begin
                        key_next = {key_reg[KEY_W-9:0], in_data_reg};
                        if (key_cnt_reg < KEY_CNT_MAX)
                        begin
                            key_cnt_next = key_cnt_reg + 4'd1;
                        end
                    end
                end
                PH_VAL:
                begin
                    if (in_data_reg == CH_BSLASH)
                    begin
                        phase_next = PH_ESC1;
                    end
                end
                PH_ESC1:
                begin
                    priority if (in_data_reg == CH_TWO)
                    begin
                        lead_next  = ESC_TWO;
                        phase_next = PH_ESC2;
                    end
                    else if (in_data_reg == CH_FIVE)
                    begin
                        lead_next  = ESC_FIVE;
                        phase_next = PH_ESC2;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_VAL;
                    end
                end
                PH_ESC2:
                begin
                    if (!((lead_reg == ESC_TWO && in_data_reg == CH_FOUR) ||
                          (lead_reg == ESC_FIVE &&
                           (in_data_reg == CH_UC_C || in_data_reg == CH_LC_C))))
                    begin
                        err_next = 1'b1;
                    end
                    lead_next  = ESC_NONE;
                    phase_next = PH_VAL;
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end

        // Verdict: drop the element state and return to the start of a value.
        if (verdict)
        begin
            incomplete = (phase_next == PH_KEY) || (phase_next == PH_ESC1) ||
                         (phase_next == PH_ESC2);
            ok_next      = !in_empty_reg && !err_next && !incomplete;
            phase_next   = PH_TERM;
            key_next     = '0;
            key_cnt_next = '0;
            lead_next    = ESC_NONE;
            err_next     = 1'b0;
            start_next   = 1'b1;
        end
        else
        begin
            incomplete = 1'b0;
        end
    end

    // Hold the incoming beat until the parser consumes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
    end

    // Advance the parse state once per consumed beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TERM;
            key_reg     <= '0;
            key_cnt_reg <= '0;
            lead_reg    <= ESC_NONE;
            err_reg     <= 1'b0;
            start_reg   <= 1'b1;
        end
        else if (go)
        begin
            phase_reg   <= phase_next;
            key_reg     <= key_next;
            key_cnt_reg <= key_cnt_next;
            lead_reg    <= lead_next;
            err_reg     <= err_next;
            start_reg   <= start_next;
        end
    end

    // Output register: load a verdict, drop it once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && verdict)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && verdict)
        begin
            out_ok_reg <= ok_next;
        end
    end

    // A second escape digit is only expected after a recognized first digit.
    `TIC_ASSERT_NEVER(a_esc2_lead, clk, rst_n, phase_reg == PH_ESC2 && lead_reg == ESC_NONE)
    // The key length counter saturates.
    `TIC_ASSERT_NEVER(a_key_cnt, clk, rst_n, key_cnt_reg > KEY_CNT_MAX)
    // Every verdict leaves the parser at the start of a fresh value.
    `TIC_ASSERT(a_verdict_reset, clk, rst_n, (go && verdict) |=> (phase_reg == PH_TERM && start_reg && !err_reg && key_cnt_reg == 4'd0))
    // A beat waits in the input register only behind an untaken verdict.
    `TIC_ASSERT(a_stall_cause, clk, rst_n, (in_valid_reg && !go) |-> (verdict && out_valid_reg && !m_tready))

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for teletex_id_syntax_checker: streams octets of teletex terminal
// identifiers and compares every verdict beat with an in-bench grammar predictor.
// Depends on tic_pkg (parse phases, escape leads, character codes) and the RTL top.
`timescale 1ns / 1ps

module tb_top;

    import tic_pkg::*;

    // Idle cycles on both sides with no beat moving before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to hold after the last verdict so a stray late beat still gets seen.
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BEATS    = 450;

    // Keys as the parser's key window holds them: first octet highest.
    localparam logic [55:0] K_MISC    = "misc";
    localparam logic [55:0] K_PAGE    = "page";
    localparam logic [55:0] K_GRAPHIC = "graphic";
    localparam logic [55:0] K_CONTROL = "control";
    localparam logic [55:0] K_PRIVATE = "private";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } beat_t;

    // Ways a well-formed value gets broken on purpose.
    typedef enum int {
        MANGLE_BYTE,          // overwrite one octet with a random one
        MANGLE_DOLLAR_IN,     // drop a '$' somewhere inside
        MANGLE_TRUNCATE,      // cut the value short (may split a key or escape)
        MANGLE_ESC_AT_END,    // end the value inside an escape
        MANGLE_DOLLAR_END,    // trailing '$'
        MANGLE_DOLLAR_START,  // leading '$'
        MANGLE_ESC_BY_DOLLAR, // escape cut short by the next element
        MANGLE_COUNT
    } mangle_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
    logic       s_tlast = 1'b0;    // last_byte
    logic       s_tuser = 1'b0;    // empty_value
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] value_ok, [7:1] zero

    teletex_id_syntax_checker uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Grammar predictor: its own copy of the parse state.
    // ------------------------------------------------------------------
    phase_t      pred_phase = PH_TERM;
    logic [55:0] key_window = '0;
    logic [3:0]  key_len    = '0;
    esc_lead_t   esc_first  = ESC_NONE;
    logic        val_bad    = 1'b0;
    logic        elem_empty = 1'b1;

    function automatic void clear_parser();
        pred_phase = PH_TERM;
        key_window = '0;
        key_len    = '0;
        esc_first  = ESC_NONE;
        val_bad    = 1'b0;
        elem_empty = 1'b1;
    endfunction

    // Element still waiting for its colon or for escape digits.
    function automatic logic elem_open();
        return pred_phase == PH_KEY || pred_phase == PH_ESC1 || pred_phase == PH_ESC2;
    endfunction

    function automatic logic printable_char(input logic [7:0] c);
        case (c)
            "'", "(", ")", "+", ",", "-", ".", "=", "/", ":", "?", " ":
                return 1'b1;
            default:
                return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                       (c >= "a" && c <= "z");
        endcase
    endfunction

    // Advance the parser by one octet; returns 1 when the beat yields a verdict.
    function automatic logic predict_beat(input logic [7:0] c, input logic last,
                                          input logic empty, output logic ok);
        logic key_hit;
        ok = 1'b0;
        if (empty)
        begin
            clear_parser();
            return 1'b1;
        end
        if (c == CH_DOLLAR)
        begin
            if (elem_empty || last || elem_open())
                val_bad = 1'b1;
            pred_phase = PH_KEY;
            key_window = '0;
            key_len    = '0;
            esc_first  = ESC_NONE;
            elem_empty = 1'b1;
        end
        else
        begin
            elem_empty = 1'b0;
            case (pred_phase)
                PH_TERM:
                    if (!printable_char(c))
                        val_bad = 1'b1;
                PH_KEY:
                    if (c == CH_COLON)
                    begin
                        if (key_len == 4'd4)
                            key_hit = key_window == K_MISC || key_window == K_PAGE;
                        else if (key_len == 4'd7)
                            key_hit = key_window == K_GRAPHIC || key_window == K_CONTROL ||
                                      key_window == K_PRIVATE;
                        else
                            key_hit = 1'b0;
                        if (!key_hit)
                            val_bad = 1'b1;
                        pred_phase = PH_VAL;
                    end
                    else
                    begin
                        key_window = {key_window[47:0], c};
                        if (key_len != 4'd8)
                            key_len = key_len + 4'd1;
                    end
                PH_VAL:
                    if (c == CH_BSLASH)
                        pred_phase = PH_ESC1;
                PH_ESC1:
                    if (c == CH_TWO)
                    begin
                        esc_first  = ESC_TWO;
                        pred_phase = PH_ESC2;
                    end
                    else if (c == CH_FIVE)
                    begin
                        esc_first  = ESC_FIVE;
                        pred_phase = PH_ESC2;
                    end
                    else
                    begin
                        val_bad    = 1'b1;
                        pred_phase = PH_VAL;
                    end
                PH_ESC2:
                begin
                    if (!((esc_first == ESC_TWO && c == CH_FOUR) ||
                          (esc_first == ESC_FIVE && (c == CH_UC_C || c == CH_LC_C))))
                        val_bad = 1'b1;
                    esc_first  = ESC_NONE;
                    pred_phase = PH_VAL;
                end
                default:
                    val_bad = 1'b1;
            endcase
        end
        if (!last)
            return 1'b0;
        if (elem_open())
            val_bad = 1'b1;
        ok = !val_bad;
        clear_parser();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    beat_t      pending_beats[$];
    logic [7:0] val_bytes[$];
    int         beats_queued = 0;

    string good_keys [0:4] = '{"misc", "page", "graphic", "control", "private"};
    // Near misses: wrong case, short, long, an 8-octet key whose last 7 match.
    string trap_keys [0:9] = '{"Misc", "pag", "pages", "graphi", "graphicx",
                               "xcontrol", "privat", "", "paGe", "controls"};
    // Escapes weighted toward the legal forms.
    string escapes [0:9] = '{"\\24", "\\5C", "\\5c", "\\24", "\\5C", "\\5c", "\\24",
                             "\\25", "\\5d", "\\x4"};

    function automatic void push_beat(input logic [7:0] data, input logic last,
                                      input logic empty);
        beat_t b;
        b.data  = data;
        b.last  = last;
        b.empty = empty;
        pending_beats.push_back(b);
        beats_queued++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            val_bytes.push_back(s[i]);
    endfunction

    // Turn val_bytes into beats; abandon_at >= 0 drops a zero-length beat after that octet.
    function automatic void queue_value(input int abandon_at);
        for (int i = 0; i < val_bytes.size(); i++)
        begin
            push_beat(val_bytes[i], i == val_bytes.size() - 1, 1'b0);
            if (i == abandon_at)
                push_beat(8'($urandom), 1'($urandom), 1'b1);
        end
    endfunction

    // Mostly well-formed identifiers with random content, some broken, some pure noise.
    function automatic void gen_value();
        logic [7:0] c;
        int         cut;
        mangle_t    how;
        val_bytes.delete();
        if ($urandom_range(99, 0) < 8)
        begin
            repeat ($urandom_range(12, 1))
                val_bytes.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(6, 1))
            begin
                do
                    c = 8'($urandom);
                while (!printable_char(c));
                val_bytes.push_back(c);
            end
            repeat ($urandom_range(3, 0))
            begin
                val_bytes.push_back(CH_DOLLAR);
                if ($urandom_range(99, 0) < 85)
                    push_text(good_keys[$urandom_range(4, 0)]);
                else
                    push_text(trap_keys[$urandom_range(9, 0)]);
                val_bytes.push_back(CH_COLON);
                repeat ($urandom_range(5, 0))
                begin
                    if ($urandom_range(99, 0) < 20)
                        push_text(escapes[$urandom_range(9, 0)]);
                    else
                    begin
                        do
                            c = 8'($urandom);
                        while (c == CH_DOLLAR || c == CH_BSLASH);
                        val_bytes.push_back(c);
                    end
                end
            end
            if ($urandom_range(99, 0) < 30)
            begin
                how = mangle_t'($urandom_range(MANGLE_COUNT - 1, 0));
                case (how)
                    MANGLE_BYTE:
                        val_bytes[$urandom_range(val_bytes.size() - 1, 0)] = 8'($urandom);
                    MANGLE_DOLLAR_IN:
                        val_bytes.insert($urandom_range(val_bytes.size() - 1, 0), CH_DOLLAR);
                    MANGLE_TRUNCATE:
                    begin
                        cut = $urandom_range(val_bytes.size(), 1);
                        while (val_bytes.size() > cut)
                            void'(val_bytes.pop_back());
                    end
                    MANGLE_ESC_AT_END:
                        if ($urandom_range(1, 0) != 0)
                            push_text("\\");
                        else
                            push_text("\\2");
                    MANGLE_DOLLAR_END:
                        val_bytes.push_back(CH_DOLLAR);
                    MANGLE_DOLLAR_START:
                        val_bytes.push_front(CH_DOLLAR);
                    default:
                        push_text("\\5$page:");
                endcase
            end
        end
        // Occasional stand-alone zero-length value with random octet and flag.
        if ($urandom_range(99, 0) < 4)
            push_beat(8'($urandom), 1'($urandom), 1'b1);
        queue_value($urandom_range(99, 0) < 4 ? $urandom_range(val_bytes.size() - 1, 0) : -1);
    endfunction

    // ------------------------------------------------------------------
    // Driver: one beat per handshake, random gaps at send_idle_pct.
    // ------------------------------------------------------------------
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    beat_t drv_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            // Slot is free: load the next beat or leave the slot idle.
            if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                drv_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_beat.data;
                s_tlast  <= drv_beat.last;
                s_tuser  <= drv_beat.empty;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check output beats first, then predict from the input beat
    // taken at the same edge, so the order of the two never matters.
    // ------------------------------------------------------------------
    logic [7:0] verdict_q[$];
    logic [7:0] want_beat;
    logic       ok_bit;
    int         beats_in         = 0;
    int         verdicts_checked = 0;
    int         valid_seen       = 0;
    int         mismatch_count   = 0;

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                    note_mismatch($sformatf("verdict beat %02h with none pending", m_tdata));
                else
                begin
                    want_beat = verdict_q.pop_front();
                    if (m_tdata !== want_beat)
                        note_mismatch($sformatf("value_ok expected %0d, got %0d (tdata %02h)",
                                                want_beat[0], m_tdata[0], m_tdata));
                    verdicts_checked++;
                    if (want_beat[0])
                        valid_seen++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                beats_in++;
                if (predict_beat(s_tdata, s_tlast, s_tuser, ok_bit))
                    verdict_q.push_back({7'b0, ok_bit});
            end
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any beat on either side restarts the count.
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles with no beat moving", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (beats_in != beats_queued || verdict_q.size() != 0)
            @(negedge clk);
    endtask

    // Set the back-pressure mix, queue a batch of random values, wait for them to drain.
    task automatic run_phase(input int send_pct, input int recv_pct);
        int target;
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target = beats_queued + PHASE_BEATS;
        while (beats_queued < target)
            gen_value();
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero-length value with junk octet, octet extremes, lone printable,
        // lone dollar, a full identifier with a lowercase escape, a value abandoned by
        // a zero-length beat, and a key with no colon.
        push_beat(8'hFF, 1'b1, 1'b1);
        push_beat(8'h00, 1'b1, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b0);
        push_beat("A", 1'b1, 1'b0);
        push_beat(CH_DOLLAR, 1'b1, 1'b0);
        val_bytes.delete();
        push_text("?$misc:\\5c");
        queue_value(-1);
        push_beat("a", 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1);
        val_bytes.delete();
        push_text("b$page");
        queue_value(-1);

        // Sender mostly busy against a reluctant receiver, then the reverse, then flat out.
        run_phase(9, 59);
        run_phase(59, 9);
        run_phase(0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Streamed %0d octet beats; checked %0d verdicts (%0d valid, %0d invalid).",
                 beats_in, verdicts_checked, valid_seen, verdicts_checked - valid_seen);
        $display("Back-pressure mixes: light/heavy, heavy/light, none; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
